@@ hw/rtl/mstseq_pkg.sv @@
// Shared types and constants for the motor self-test sequencer.
`default_nettype none
package mstseq_pkg;

    localparam int unsigned PAUSE_MS    = 500;
    localparam int unsigned MOTOR_COUNT = 4;

    localparam int unsigned NOW_W   = 32;
    localparam int unsigned RATIO_W = 16;
    localparam int unsigned DUR_W   = 24;
    localparam int unsigned MOTOR_W = 2;
    localparam int unsigned SLOT_W  = DUR_W + 1;
    localparam int unsigned CFG_W   = DUR_W;
    localparam int unsigned CFG_IDX_W = 2;

    localparam int unsigned DIV_STEPS  = NOW_W;
    localparam int unsigned STEP_W     = $clog2(DIV_STEPS);
    localparam int unsigned N_ENTRIES  = 5;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx REG_MOTOR_SELECT = 2'd0;
    localparam t_cfg_idx REG_TEST_THRUST  = 2'd1;
    localparam t_cfg_idx REG_DURATION_MS  = 2'd2;

    localparam logic CMD_SET  = 1'b0;
    localparam logic CMD_STOP = 1'b1;

    // fixed slots of the result buffer, in delivery order
    typedef logic [2:0] t_entry;
    localparam t_entry E_SGL_STOP = 3'd0;
    localparam t_entry E_SGL_RUN  = 3'd1;
    localparam t_entry E_SGL_ZERO = 3'd2;
    localparam t_entry E_SEQ_STOP = 3'd3;
    localparam t_entry E_SEQ_SET  = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CTRL,
        ST_DIV,
        ST_SEQ,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [NOW_W-1:0] now_ms;
        logic             start_single;
        logic             start_sequence;
        logic             stop_all;
    } t_in_word;

    typedef struct packed {
        logic               cmd_kind;
        logic [MOTOR_W-1:0] motor_index;
        logic [RATIO_W-1:0] ratio;
        logic               last;
    } t_out_word;

endpackage
`default_nettype wire

@@ hw/rtl/motor_self_test_sequencer.sv @@
// Motor self-test sequencer: tick handling, slot divider and result buffer.
//
// Each input word is one millisecond tick. A tick with no sequence running is
// decided in the control state; with the sequential test running it also passes
// through the 32-step restoring divider that splits the elapsed time into slot
// number and slot offset. The input stall stays high from acceptance until the
// tick is decided and its last result word, if any, has been taken.
// Configuration writes are taken in any cycle (ready is always high).
// PAUSE_MS sets the pause after each slot and MOTOR_COUNT the motors in a sequence.
`default_nettype none
module motor_self_test_sequencer #(
    parameter int unsigned PAUSE_MS    = mstseq_pkg::PAUSE_MS,
    parameter int unsigned MOTOR_COUNT = mstseq_pkg::MOTOR_COUNT
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    input  wire mstseq_pkg::t_in_word           i_in_word,
    output logic                                o_in_stall,
    output logic                                o_out_valid,
    output mstseq_pkg::t_out_word               o_out_word,
    input  wire                                 i_out_stall,
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [mstseq_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  [mstseq_pkg::CFG_W-1:0]        i_cfg_data
);

    localparam int unsigned NW = mstseq_pkg::NOW_W;
    localparam int unsigned SW = mstseq_pkg::SLOT_W;
    localparam int unsigned NE = mstseq_pkg::N_ENTRIES;

    localparam logic [NE-1:0] M_SGL_STOP = NE'(1) << mstseq_pkg::E_SGL_STOP;
    localparam logic [NE-1:0] M_SGL_RUN  = NE'(1) << mstseq_pkg::E_SGL_RUN;
    localparam logic [NE-1:0] M_SGL_ZERO = NE'(1) << mstseq_pkg::E_SGL_ZERO;
    localparam logic [NE-1:0] M_SEQ_STOP = NE'(1) << mstseq_pkg::E_SEQ_STOP;
    localparam logic [NE-1:0] M_SEQ_SET  = NE'(1) << mstseq_pkg::E_SEQ_SET;

    mstseq_pkg::t_state r_state, n_state;

    // configuration
    logic [mstseq_pkg::MOTOR_W-1:0] r_motor_select;
    logic [mstseq_pkg::RATIO_W-1:0] r_test_thrust;
    logic [mstseq_pkg::DUR_W-1:0]   r_duration;

    // latched tick
    logic [NW-1:0] r_now, n_now;
    logic          r_req_single, n_req_single;
    logic          r_req_seq, n_req_seq;
    logic          r_req_stop, n_req_stop;

    // test state
    logic          r_single_pending, n_single_pending;
    logic          r_single_active, n_single_active;
    logic [NW-1:0] r_single_start, n_single_start;
    logic          r_seq_running, n_seq_running;
    logic          r_seq_started, n_seq_started;
    logic [NW-1:0] r_seq_start, n_seq_start;
    logic [mstseq_pkg::MOTOR_W-1:0] r_seq_motor, n_seq_motor;
    logic          r_seq_thrust, n_seq_thrust;

    // divider: r_quo holds the dividend and collects the quotient bits
    logic [NW-1:0]   r_quo, n_quo;
    logic [SW-1:0]   r_rem, n_rem;
    logic [mstseq_pkg::STEP_W-1:0] r_step, n_step;

    // pending result words
    logic [NE-1:0] r_mask, n_mask;

    logic          in_acc, out_acc;
    logic          c_pend, c_start, c_act, c_done, c_run, c_started;
    logic [NW-1:0] c_st, c_el_s, c_el_q;
    logic [SW-1:0] c_slot;
    logic [SW:0]   c_trial;
    logic          c_ge, c_seq_ok;
    logic [NE-1:0] c_mask_ctrl, c_mask_seq, c_low;
    logic          c_last;
    mstseq_pkg::t_entry c_sel;

    assign in_acc  = i_in_valid & ~o_in_stall;
    assign out_acc = o_out_valid & ~i_out_stall;

    // single test decision
    assign c_pend    = r_single_pending | r_req_single;
    assign c_start   = c_pend & ~r_single_active;
    assign c_act     = r_single_active | c_start;
    assign c_st      = c_start ? r_now : r_single_start;
    assign c_el_s    = r_now - c_st;
    assign c_done    = c_act & (c_el_s >= {{(NW-mstseq_pkg::DUR_W){1'b0}}, r_duration});
    assign c_run     = r_seq_running | r_req_seq;
    assign c_started = r_seq_started & ~r_req_seq;
    assign c_el_q    = c_started ? (r_now - r_seq_start) : '0;

    assign c_mask_ctrl = r_req_stop ? M_SGL_STOP :
                         ((c_start ? (M_SGL_STOP | M_SGL_RUN) : '0) |
                          (c_done ? M_SGL_ZERO : '0));

    // slot length and one restoring step
    assign c_slot  = {1'b0, r_duration} + SW'(PAUSE_MS);
    assign c_trial = {r_rem, r_quo[NW-1]};
    assign c_ge    = c_trial >= {1'b0, c_slot};

    assign c_seq_ok = (c_slot != '0) && (r_quo < NW'(MOTOR_COUNT));
    always_comb begin
        if (!c_seq_ok) begin
            c_mask_seq = r_mask | M_SEQ_STOP;
        end else if (r_rem == '0) begin
            c_mask_seq = r_mask | M_SEQ_STOP | M_SEQ_SET;
        end else if (r_rem >= {1'b0, r_duration}) begin
            c_mask_seq = r_mask | M_SEQ_SET;
        end else begin
            c_mask_seq = r_mask;
        end
    end

    // lowest pending entry goes out first
    assign c_low  = r_mask & (~r_mask + NE'(1));
    assign c_last = (r_mask & ~c_low) == '0;
    always_comb begin
        c_sel = mstseq_pkg::E_SGL_STOP;
        for (int i = NE - 1; i >= 0; i--) begin
            if (r_mask[i]) c_sel = mstseq_pkg::t_entry'(i);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mstseq_pkg::ST_IDLE: begin
                if (in_acc) n_state = mstseq_pkg::ST_CTRL;
            end
            mstseq_pkg::ST_CTRL: begin
                if (!r_req_stop && c_run) begin
                    n_state = mstseq_pkg::ST_DIV;
                end else if (c_mask_ctrl != '0) begin
                    n_state = mstseq_pkg::ST_EMIT;
                end else begin
                    n_state = mstseq_pkg::ST_IDLE;
                end
            end
            mstseq_pkg::ST_DIV: begin
                if (r_step == mstseq_pkg::STEP_W'(mstseq_pkg::DIV_STEPS - 1))
                    n_state = mstseq_pkg::ST_SEQ;
            end
            mstseq_pkg::ST_SEQ: begin
                n_state = (c_mask_seq != '0) ? mstseq_pkg::ST_EMIT : mstseq_pkg::ST_IDLE;
            end
            mstseq_pkg::ST_EMIT: begin
                if (out_acc && c_last) n_state = mstseq_pkg::ST_IDLE;
            end
            default: n_state = mstseq_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_stall  = r_state != mstseq_pkg::ST_IDLE;
        o_out_valid = r_state == mstseq_pkg::ST_EMIT;
        o_cfg_ready = 1'b1;
        o_out_word.last = c_last;
        unique case (c_sel)
            mstseq_pkg::E_SGL_RUN: begin
                o_out_word.cmd_kind    = mstseq_pkg::CMD_SET;
                o_out_word.motor_index = r_motor_select;
                o_out_word.ratio       = r_test_thrust;
            end
            mstseq_pkg::E_SGL_ZERO: begin
                o_out_word.cmd_kind    = mstseq_pkg::CMD_SET;
                o_out_word.motor_index = r_motor_select;
                o_out_word.ratio       = '0;
            end
            mstseq_pkg::E_SEQ_SET: begin
                o_out_word.cmd_kind    = mstseq_pkg::CMD_SET;
                o_out_word.motor_index = r_seq_motor;
                o_out_word.ratio       = r_seq_thrust ? r_test_thrust : '0;
            end
            default: begin
                o_out_word.cmd_kind    = mstseq_pkg::CMD_STOP;
                o_out_word.motor_index = '0;
                o_out_word.ratio       = '0;
            end
        endcase
    end

    // datapath next values
    always_comb begin
        n_now            = r_now;
        n_req_single     = r_req_single;
        n_req_seq        = r_req_seq;
        n_req_stop       = r_req_stop;
        n_single_pending = r_single_pending;
        n_single_active  = r_single_active;
        n_single_start   = r_single_start;
        n_seq_running    = r_seq_running;
        n_seq_started    = r_seq_started;
        n_seq_start      = r_seq_start;
        n_seq_motor      = r_seq_motor;
        n_seq_thrust     = r_seq_thrust;
        n_quo            = r_quo;
        n_rem            = r_rem;
        n_step           = r_step;
        n_mask           = r_mask;
        unique case (r_state)
            mstseq_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_now        = i_in_word.now_ms;
                    n_req_single = i_in_word.start_single;
                    n_req_seq    = i_in_word.start_sequence;
                    n_req_stop   = i_in_word.stop_all;
                end
            end
            mstseq_pkg::ST_CTRL: begin
                n_mask = c_mask_ctrl;
                if (r_req_stop) begin
                    n_single_pending = 1'b0;
                    n_single_active  = 1'b0;
                    n_seq_running    = 1'b0;
                    n_seq_started    = 1'b0;
                    n_seq_motor      = '0;
                end else begin
                    n_single_pending = c_pend & ~c_done;
                    n_single_active  = c_act & ~c_done;
                    n_single_start   = c_st;
                    n_seq_running    = c_run;
                    n_seq_started    = c_run | c_started;
                    if (c_run && !c_started) n_seq_start = r_now;
                    if (r_req_seq) n_seq_motor = '0;
                    n_quo  = c_el_q;
                    n_rem  = '0;
                    n_step = '0;
                end
            end
            mstseq_pkg::ST_DIV: begin
                n_rem  = c_ge ? SW'(c_trial - {1'b0, c_slot}) : c_trial[SW-1:0];
                n_quo  = {r_quo[NW-2:0], c_ge};
                n_step = r_step + 1'b1;
            end
            mstseq_pkg::ST_SEQ: begin
                n_mask = c_mask_seq;
                if (c_seq_ok) begin
                    n_seq_motor  = r_quo[mstseq_pkg::MOTOR_W-1:0];
                    n_seq_thrust = r_rem == '0;
                end else begin
                    n_seq_running = 1'b0;
                    n_seq_started = 1'b0;
                    n_seq_motor   = '0;
                end
            end
            mstseq_pkg::ST_EMIT: begin
                if (out_acc) n_mask = r_mask & ~c_low;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= mstseq_pkg::ST_IDLE;
            r_motor_select   <= '0;
            r_test_thrust    <= mstseq_pkg::RATIO_W'(20000);
            r_duration       <= mstseq_pkg::DUR_W'(1000);
            r_single_pending <= 1'b0;
            r_single_active  <= 1'b0;
            r_single_start   <= '0;
            r_seq_running    <= 1'b0;
            r_seq_started    <= 1'b0;
            r_seq_start      <= '0;
            r_seq_motor      <= '0;
            r_mask           <= '0;
            r_step           <= '0;
        end else begin
            r_state          <= n_state;
            r_single_pending <= n_single_pending;
            r_single_active  <= n_single_active;
            r_single_start   <= n_single_start;
            r_seq_running    <= n_seq_running;
            r_seq_started    <= n_seq_started;
            r_seq_start      <= n_seq_start;
            r_seq_motor      <= n_seq_motor;
            r_mask           <= n_mask;
            r_step           <= n_step;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    mstseq_pkg::REG_MOTOR_SELECT:
                        r_motor_select <= i_cfg_data[mstseq_pkg::MOTOR_W-1:0];
                    mstseq_pkg::REG_TEST_THRUST:
                        r_test_thrust <= i_cfg_data[mstseq_pkg::RATIO_W-1:0];
                    mstseq_pkg::REG_DURATION_MS:
                        r_duration <= i_cfg_data[mstseq_pkg::DUR_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_now        <= n_now;
        r_req_single <= n_req_single;
        r_req_seq    <= n_req_seq;
        r_req_stop   <= n_req_stop;
        r_seq_thrust <= n_seq_thrust;
        r_quo        <= n_quo;
        r_rem        <= n_rem;
    end

    a_emit_has_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mstseq_pkg::ST_EMIT) |-> (r_mask != '0))
        else $error("emit state with no pending word");

    a_active_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_single_active |-> r_single_pending)
        else $error("single test active without pending flag");

    a_started_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seq_started |-> r_seq_running)
        else $error("sequence started flag set while not running");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mstseq_pkg::ST_SEQ && c_slot != '0) |-> (r_rem < c_slot))
        else $error("divider remainder not below slot length");

    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_out_word.last) |=> (r_state == mstseq_pkg::ST_IDLE))
        else $error("last word taken but sequencer not idle");

endmodule
`default_nettype wire
